@@ rtl/core/tvbb_pkg.sv @@
// Shared types, constants and helpers for the transformed vertex bounding box.
// Used by every module of the block; depends on nothing else.
package tvbb_pkg;

	// Fixed-point format and datapath widths
	localparam int unsigned COORD_W   = 32;
	localparam int unsigned FRAC_BITS = 16;
	localparam int unsigned PROD_W    = 2 * COORD_W;
	localparam int unsigned SUM_W     = PROD_W + 2;
	localparam int unsigned SHIFT_W   = SUM_W - FRAC_BITS;
	localparam int unsigned AXIS_W    = SHIFT_W + 1;
	localparam int unsigned NUM_AXES  = 3;
	localparam int unsigned NUM_PROD  = NUM_AXES * NUM_AXES;

	// Configuration port
	localparam int unsigned NUM_REGS  = 6;
	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned CFG_W     = 64;

	// Vertex queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_XX_XY = 3'd0,
		REG_XZ_XT = 3'd1,
		REG_YX_YY = 3'd2,
		REG_YZ_YT = 3'd3,
		REG_ZX_ZY = 3'd4,
		REG_ZZ_ZT = 3'd5
	} reg_idx_t;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [CFG_W-1:0]          cfg_word_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		logic   last;
	} vertex_t;

	typedef struct packed {
		cfg_word_t xx_xy;
		cfg_word_t xz_xt;
		cfg_word_t yx_yy;
		cfg_word_t yz_yt;
		cfg_word_t zx_zy;
		cfg_word_t zz_zt;
	} matrix_t;

	typedef struct packed {
		coord_t min_x;
		coord_t min_y;
		coord_t min_z;
		coord_t max_x;
		coord_t max_y;
		coord_t max_z;
	} box_t;

	// Queue status seen by the front and the back
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
	localparam coord_t COORD_MIN = 32'sh8000_0000;
	localparam logic signed [AXIS_W-1:0] AXIS_MAX = AXIS_W'(COORD_MAX);
	localparam logic signed [AXIS_W-1:0] AXIS_MIN = AXIS_W'(COORD_MIN);

	// Identity transform at reset: 1.0 in Q16.16 in the high or low half
	localparam cfg_word_t ONE_HI = 64'h0000_0001_0000_0000 << FRAC_BITS;
	localparam cfg_word_t ONE_LO = 64'h0000_0000_0001_0000;
	localparam matrix_t MATRIX_RESET = '{
		xx_xy: ONE_HI,
		xz_xt: '0,
		yx_yy: ONE_LO,
		yz_yt: '0,
		zx_zy: '0,
		zz_zt: ONE_HI
	};

	function automatic coord_t hi_half(input cfg_word_t w);
		return coord_t'(w[CFG_W-1:COORD_W]);
	endfunction

	function automatic coord_t lo_half(input cfg_word_t w);
		return coord_t'(w[COORD_W-1:0]);
	endfunction

	// Clamp a widened axis result to the signed 32-bit range
	function automatic coord_t saturate(input logic signed [AXIS_W-1:0] v);
		coord_t r;
		if (v > AXIS_MAX) begin
			r = COORD_MAX;
		end else if (v < AXIS_MIN) begin
			r = COORD_MIN;
		end else begin
			r = coord_t'(v[COORD_W-1:0]);
		end
		return r;
	endfunction

endpackage

@@ rtl/core/tvbb_front.sv @@
// Front end: configuration register file and input transaction acceptance.
// Packs accepted vertices for the queue. Depends on tvbb_pkg.
module tvbb_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tvbb_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [tvbb_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [tvbb_pkg::COORD_W-1:0] vertex_x,
	input  logic signed [tvbb_pkg::COORD_W-1:0] vertex_y,
	input  logic signed [tvbb_pkg::COORD_W-1:0] vertex_z,
	input  logic                              last_vertex,
	input  tvbb_pkg::queue_status_t           q_status,
	output logic                              push,
	output tvbb_pkg::vertex_t                 push_data,
	output tvbb_pkg::matrix_t                 matrix
);

	tvbb_pkg::matrix_t matrix_q;

	// Register writes are always taken; unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_q <= tvbb_pkg::MATRIX_RESET;
		end else if (cfg_valid) begin
			unique case (tvbb_pkg::reg_idx_t'(cfg_index))
				tvbb_pkg::REG_XX_XY: matrix_q.xx_xy <= cfg_data;
				tvbb_pkg::REG_XZ_XT: matrix_q.xz_xt <= cfg_data;
				tvbb_pkg::REG_YX_YY: matrix_q.yx_yy <= cfg_data;
				tvbb_pkg::REG_YZ_YT: matrix_q.yz_yt <= cfg_data;
				tvbb_pkg::REG_ZX_ZY: matrix_q.zx_zy <= cfg_data;
				tvbb_pkg::REG_ZZ_ZT: matrix_q.zz_zt <= cfg_data;
				default: ;
			endcase
		end
	end

	assign matrix = matrix_q;

	// Vertex transactions go straight into the queue while it has room
	assign in_ready = !q_status.full;
	assign push     = in_valid && !q_status.full;

	always_comb begin
		push_data.x    = vertex_x;
		push_data.y    = vertex_y;
		push_data.z    = vertex_z;
		push_data.last = last_vertex;
	end

endmodule

@@ rtl/core/tvbb_queue.sv @@
// Short vertex queue decoupling the front end from the transform pipeline.
// Depends on tvbb_pkg.
module tvbb_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  tvbb_pkg::vertex_t       push_data,
	input  logic                    pop,
	output tvbb_pkg::queue_status_t status,
	output tvbb_pkg::vertex_t       head
);

	tvbb_pkg::vertex_t                mem_q [tvbb_pkg::QUEUE_DEPTH];
	logic [tvbb_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [tvbb_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [tvbb_pkg::QCNT_W-1:0]      count_q;

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head         = mem_q[rd_ptr_q];
	assign status.full  = (count_q == tvbb_pkg::QCNT_W'(tvbb_pkg::QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

endmodule

@@ rtl/core/tvbb_back.sv @@
// Back end: affine transform pipeline, running min/max fold and output register.
// Depends on tvbb_pkg.
module tvbb_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tvbb_pkg::matrix_t         matrix,
	input  tvbb_pkg::queue_status_t   q_status,
	input  tvbb_pkg::vertex_t         head,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output tvbb_pkg::box_t            box
);

	localparam int unsigned NA = tvbb_pkg::NUM_AXES;
	localparam int unsigned NP = tvbb_pkg::NUM_PROD;

	logic                                   en;
	tvbb_pkg::coord_t                       coef      [NP];
	tvbb_pkg::coord_t                       operand   [NA];
	tvbb_pkg::coord_t                       trans     [NA];
	logic signed [tvbb_pkg::PROD_W-1:0]     prod_c    [NP];
	logic signed [tvbb_pkg::AXIS_W-1:0]     axis_c    [NA];
	tvbb_pkg::coord_t                       nmin_c    [NA];
	tvbb_pkg::coord_t                       nmax_c    [NA];

	logic                                   valid_s1, valid_s2, valid_s3;
	logic                                   last_s1, last_s2, last_s3;
	logic signed [tvbb_pkg::PROD_W-1:0]     prod_s1   [NP];
	logic signed [tvbb_pkg::SUM_W-1:0]      sum_s2    [NA];
	tvbb_pkg::coord_t                       coord_s3  [NA];
	tvbb_pkg::coord_t                       run_min_q [NA];
	tvbb_pkg::coord_t                       run_max_q [NA];
	logic                                   out_valid_q;
	tvbb_pkg::box_t                         box_q;

	// Whole pipeline moves unless a finished box is waiting at the output
	assign en  = !out_valid_q || out_ready;
	assign pop = en && !q_status.empty;

	// Coefficients in row order, vertex operand per column
	always_comb begin
		coef[0]    = tvbb_pkg::hi_half(matrix.xx_xy);
		coef[1]    = tvbb_pkg::lo_half(matrix.xx_xy);
		coef[2]    = tvbb_pkg::hi_half(matrix.xz_xt);
		coef[3]    = tvbb_pkg::hi_half(matrix.yx_yy);
		coef[4]    = tvbb_pkg::lo_half(matrix.yx_yy);
		coef[5]    = tvbb_pkg::hi_half(matrix.yz_yt);
		coef[6]    = tvbb_pkg::hi_half(matrix.zx_zy);
		coef[7]    = tvbb_pkg::lo_half(matrix.zx_zy);
		coef[8]    = tvbb_pkg::hi_half(matrix.zz_zt);
		trans[0]   = tvbb_pkg::lo_half(matrix.xz_xt);
		trans[1]   = tvbb_pkg::lo_half(matrix.yz_yt);
		trans[2]   = tvbb_pkg::lo_half(matrix.zz_zt);
		operand[0] = head.x;
		operand[1] = head.y;
		operand[2] = head.z;
	end

	// Nine 32x32 signed products, full Q32.32 width
	always_comb begin
		for (int i = 0; i < NP; i++) begin
			prod_c[i] = tvbb_pkg::PROD_W'(coef[i]) * tvbb_pkg::PROD_W'(operand[i % NA]);
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= pop;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Floor shift of the exact sum, then translation and clamp
	always_comb begin
		for (int a = 0; a < NA; a++) begin
			axis_c[a] = tvbb_pkg::AXIS_W'($signed(sum_s2[a][tvbb_pkg::SUM_W-1:tvbb_pkg::FRAC_BITS]))
				+ tvbb_pkg::AXIS_W'(trans[a]);
		end
	end

	// Pipeline payload: s1 products, s2 row sums, s3 clamped coordinates
	always_ff @(posedge clk) begin
		if (en) begin
			last_s1 <= head.last;
			last_s2 <= last_s1;
			last_s3 <= last_s2;
			for (int i = 0; i < NP; i++) begin
				prod_s1[i] <= prod_c[i];
			end
			for (int a = 0; a < NA; a++) begin
				sum_s2[a]   <= tvbb_pkg::SUM_W'(prod_s1[NA*a])
					+ tvbb_pkg::SUM_W'(prod_s1[NA*a+1])
					+ tvbb_pkg::SUM_W'(prod_s1[NA*a+2]);
				coord_s3[a] <= tvbb_pkg::saturate(axis_c[a]);
			end
		end
	end

	// Running box with the current vertex folded in
	always_comb begin
		for (int a = 0; a < NA; a++) begin
			nmin_c[a] = (coord_s3[a] < run_min_q[a]) ? coord_s3[a] : run_min_q[a];
			nmax_c[a] = (coord_s3[a] > run_max_q[a]) ? coord_s3[a] : run_max_q[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NA; a++) begin
				run_min_q[a] <= tvbb_pkg::COORD_MAX;
				run_max_q[a] <= tvbb_pkg::COORD_MIN;
			end
		end else if (en && valid_s3) begin
			for (int a = 0; a < NA; a++) begin
				run_min_q[a] <= last_s3 ? tvbb_pkg::COORD_MAX : nmin_c[a];
				run_max_q[a] <= last_s3 ? tvbb_pkg::COORD_MIN : nmax_c[a];
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s3 && last_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s3 && last_s3) begin
			box_q.min_x <= nmin_c[0];
			box_q.min_y <= nmin_c[1];
			box_q.min_z <= nmin_c[2];
			box_q.max_x <= nmax_c[0];
			box_q.max_y <= nmax_c[1];
			box_q.max_z <= nmax_c[2];
		end
	end

	assign out_valid = out_valid_q;
	assign box       = box_q;

endmodule

@@ rtl/core/transformed_vertex_bounding_box.sv @@
// Transformed vertex bounding box: affine transform of a vertex stream with a
// per-axis running min/max. Top level; depends on tvbb_pkg, tvbb_front,
// tvbb_queue and tvbb_back.
//
// Usage:
//   - cfg channel: writes one 64-bit matrix register per transaction (index 0..5);
//     always ready, other indexes are ignored. Write only while the block is idle.
//   - in channel: one vertex (x, y, z in signed Q16.16, plus last_vertex) per
//     transaction, one per cycle sustained while in_ready is high.
//   - out channel: one box transaction per vertex marked last, holding the
//     running box including that vertex; the running box then returns to empty.
//   - Path: a box is presented once its last vertex has passed through the
//     queue, product stage, sum stage and clamp stage, then the fold into the
//     output register. Throughput is one vertex per cycle while no box is stalled.
//   - Backpressure: while a box waits on out_ready the transform pipeline holds;
//     a 4-entry queue keeps taking vertices until full, then in_ready drops.
//   - Reset: matrix returns to identity, running box to empty, queue and
//     pipeline are flushed, no output is presented.
module transformed_vertex_bounding_box (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tvbb_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [tvbb_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [tvbb_pkg::COORD_W-1:0] vertex_x,
	input  logic signed [tvbb_pkg::COORD_W-1:0] vertex_y,
	input  logic signed [tvbb_pkg::COORD_W-1:0] vertex_z,
	input  logic                                last_vertex,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [tvbb_pkg::COORD_W-1:0] box_min_x,
	output logic signed [tvbb_pkg::COORD_W-1:0] box_min_y,
	output logic signed [tvbb_pkg::COORD_W-1:0] box_min_z,
	output logic signed [tvbb_pkg::COORD_W-1:0] box_max_x,
	output logic signed [tvbb_pkg::COORD_W-1:0] box_max_y,
	output logic signed [tvbb_pkg::COORD_W-1:0] box_max_z
);

	tvbb_pkg::queue_status_t q_status;
	tvbb_pkg::vertex_t       push_data;
	tvbb_pkg::vertex_t       head;
	tvbb_pkg::matrix_t       matrix;
	tvbb_pkg::box_t          box;
	logic                    push;
	logic                    pop;

	tvbb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.vertex_x   (vertex_x),
		.vertex_y   (vertex_y),
		.vertex_z   (vertex_z),
		.last_vertex(last_vertex),
		.q_status   (q_status),
		.push       (push),
		.push_data  (push_data),
		.matrix     (matrix)
	);

	tvbb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.status   (q_status),
		.head     (head)
	);

	tvbb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.matrix   (matrix),
		.q_status (q_status),
		.head     (head),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.box      (box)
	);

	assign box_min_x = box.min_x;
	assign box_min_y = box.min_y;
	assign box_min_z = box.min_z;
	assign box_max_x = box.max_x;
	assign box_max_y = box.max_y;
	assign box_max_z = box.max_z;

endmodule

@@ rtl/core/tvbb_checker.sv @@
// Port-level checks for the transformed vertex bounding box, bound to the top.
// Depends on tvbb_pkg and transformed_vertex_bounding_box.
module tvbb_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [tvbb_pkg::COORD_W-1:0] box_min_x,
	input logic signed [tvbb_pkg::COORD_W-1:0] box_min_y,
	input logic signed [tvbb_pkg::COORD_W-1:0] box_min_z,
	input logic signed [tvbb_pkg::COORD_W-1:0] box_max_x,
	input logic signed [tvbb_pkg::COORD_W-1:0] box_max_y,
	input logic signed [tvbb_pkg::COORD_W-1:0] box_max_z
);

	// A stalled box transaction stays presented
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("box transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(box_min_x) && $stable(box_max_x)
			&& $stable(box_min_y) && $stable(box_max_y)
			&& $stable(box_min_z) && $stable(box_max_z))
		else $error("box payload changed while stalled");

	// An emitted box always holds at least one vertex
	a_box_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> box_min_x <= box_max_x && box_min_y <= box_max_y
			&& box_min_z <= box_max_z)
		else $error("empty or inverted box emitted");

	// The queue only fills up behind a stalled output
	a_full_needs_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> $past(out_valid && !out_ready))
		else $error("input stalled without output backpressure");

endmodule

bind transformed_vertex_bounding_box tvbb_checker u_checker (.*);
